[src/kld_pkg.sv]
// Shared types and constants for the k-mer lattice deposition block.
// No dependencies; every other file but kld_wrap_unit refers to it by scoped names.
package kld_pkg;

   localparam int COORD_W = 4;
   localparam int ATT_W   = 16;
   localparam int CNT_W   = 7;

   typedef logic [1:0] mark_type;

   localparam mark_type MARK_EMPTY = 2'd0;
   localparam mark_type MARK_HOR   = 2'd1;
   localparam mark_type MARK_VER   = 2'd2;

   localparam logic FUNC_VER = 1'b1;

   localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;
   localparam logic [ATT_W-1:0] ATT_MAX = 16'hFFFF;

   typedef struct packed {
      logic               func;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } req_type;

   typedef struct packed {
      logic               placed;
      logic [ATT_W-1:0]   attempt_number;
      logic [COORD_W-1:0] start_index;
      logic [CNT_W-1:0]   total_placed;
      logic [CNT_W-1:0]   horizontal_placed;
      logic [CNT_W-1:0]   vertical_placed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RED_ROW,
      ST_RED_COL,
      ST_READ,
      ST_TEST,
      ST_WRITE,
      ST_FINISH
   } state_type;

endpackage

[src/kld_if.sv]
// Valid/ready channels for deposition requests and their results.
// Depends on kld_pkg for the payload types.
interface kld_req_if;
   logic              valid;
   logic              ready;
   kld_pkg::req_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface kld_rsp_if;
   logic              valid;
   logic              ready;
   kld_pkg::rsp_type  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[src/kmer_lattice_deposition.sv]
// K-mer deposition on a periodic ROWS x COLS lattice, one request at a time.
// Row and column reduction, then a read and test of each of the KLEN cells, a write
// of each cell when all were empty, and the result register, loaded once any previous
// result has been taken; the next request is taken in the cycle after the result is
// registered. The lattice memory is read and written one cell per step.
// Synchronous reset starts a clearing pass of all ROWS*COLS cells with no request taken.
module kmer_lattice_deposition #(
   parameter int ROWS = 16,
   parameter int COLS = 16,
   parameter int KLEN = 3
) (
   input  logic        clock,
   input  logic        reset,
   kld_req_if.sink     req_ch,
   kld_rsp_if.source   rsp_ch
);

   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLS);

   logic [RW-1:0]     rd_row;
   logic [CW-1:0]     rd_col;
   kld_pkg::mark_type rd_mark;
   logic              wr_en;
   logic [RW-1:0]     wr_row;
   logic [CW-1:0]     wr_col;
   kld_pkg::mark_type wr_mark;

   kld_ctrl #(
      .ROWS (ROWS),
      .COLS (COLS),
      .KLEN (KLEN)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .rd_row  (rd_row),
      .rd_col  (rd_col),
      .rd_mark (rd_mark),
      .wr_en   (wr_en),
      .wr_row  (wr_row),
      .wr_col  (wr_col),
      .wr_mark (wr_mark)
   );

   kld_lattice #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_lattice (
      .clock   (clock),
      .rd_row  (rd_row),
      .rd_col  (rd_col),
      .rd_mark (rd_mark),
      .wr_en   (wr_en),
      .wr_row  (wr_row),
      .wr_col  (wr_col),
      .wr_mark (wr_mark)
   );

endmodule

[src/kld_wrap_unit.sv]
// Shared compare-and-subtract unit: reduces a value below a modulus by one step.
// Used for coordinate reduction, wrapped stepping and the clearing sweep.
module kld_wrap_unit #(
   parameter int W = 7
) (
   input  logic [W-1:0] operand,
   input  logic [W-1:0] modulus,
   output logic [W-1:0] result,
   output logic         wrapped
);

   assign wrapped = (operand >= modulus);
   assign result  = wrapped ? (operand - modulus) : operand;

endmodule

[src/kld_lattice.sv]
// Lattice mark memory: one write port and one read port with registered data.
// Depends on kld_pkg for the mark type.
module kld_lattice #(
   parameter int ROWS = 16,
   parameter int COLS = 16
) (
   input  logic                     clock,
   input  logic [$clog2(ROWS)-1:0]  rd_row,
   input  logic [$clog2(COLS)-1:0]  rd_col,
   output kld_pkg::mark_type        rd_mark,
   input  logic                     wr_en,
   input  logic [$clog2(ROWS)-1:0]  wr_row,
   input  logic [$clog2(COLS)-1:0]  wr_col,
   input  kld_pkg::mark_type        wr_mark
);

   kld_pkg::mark_type mem [ROWS][COLS];
   kld_pkg::mark_type rd_mark_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row][wr_col] <= wr_mark;
      end
      rd_mark_ff <= mem[rd_row][rd_col];
   end

   assign rd_mark = rd_mark_ff;

endmodule

[src/kld_ctrl.sv]
// Sequencer: coordinate reduction, cell-by-cell check and mark, counters, result register.
// Depends on kld_pkg, kld_if and kld_wrap_unit.
module kld_ctrl #(
   parameter int ROWS = 16,
   parameter int COLS = 16,
   parameter int KLEN = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   kld_req_if.sink                  req_ch,
   kld_rsp_if.source                rsp_ch,
   output logic [$clog2(ROWS)-1:0]  rd_row,
   output logic [$clog2(COLS)-1:0]  rd_col,
   input  kld_pkg::mark_type        rd_mark,
   output logic                     wr_en,
   output logic [$clog2(ROWS)-1:0]  wr_row,
   output logic [$clog2(COLS)-1:0]  wr_col,
   output kld_pkg::mark_type        wr_mark
);

   localparam int RW  = $clog2(ROWS);
   localparam int CW  = $clog2(COLS);
   localparam int MW  = $clog2(((ROWS > COLS) ? ROWS : COLS) + 1);
   localparam int WW  = (MW > kld_pkg::COORD_W) ? MW : kld_pkg::COORD_W;
   localparam int KW  = $clog2(KLEN + 1);

   localparam logic [WW-1:0] ROWS_W = WW'(ROWS);
   localparam logic [WW-1:0] COLS_W = WW'(COLS);
   localparam logic [WW-1:0] ONE_W  = WW'(1);
   localparam logic [KW-1:0] KLAST  = KW'(KLEN - 1);

   kld_pkg::state_type            state_ff, state_in;
   logic                          func_ff, func_in;
   logic [WW-1:0]                 row_ff, row_in;
   logic [WW-1:0]                 col_ff, col_in;
   logic [WW-1:0]                 cur_ff, cur_in;
   logic [KW-1:0]                 idx_ff, idx_in;
   logic                          empty_ff, empty_in;
   logic [kld_pkg::ATT_W-1:0]     attempt_ff, attempt_in;
   logic [kld_pkg::CNT_W-1:0]     total_ff, total_in;
   logic [kld_pkg::CNT_W-1:0]     hor_ff, hor_in;
   logic [kld_pkg::CNT_W-1:0]     ver_ff, ver_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   kld_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic [WW-1:0]                 unit_op;
   logic [WW-1:0]                 unit_mod;
   logic [WW-1:0]                 unit_res;
   logic                          unit_wrap;
   logic [WW-1:0]                 vrow;
   logic [WW-1:0]                 vcol;
   logic [WW-1:0]                 start_sel;
   logic                          is_vert;
   logic [kld_pkg::CNT_W-1:0]     total_nx;
   logic [kld_pkg::CNT_W-1:0]     hor_nx;
   logic [kld_pkg::CNT_W-1:0]     ver_nx;

   kld_wrap_unit #(.W(WW)) u_wrap (
      .operand (unit_op),
      .modulus (unit_mod),
      .result  (unit_res),
      .wrapped (unit_wrap)
   );

   assign is_vert   = (func_ff == kld_pkg::FUNC_VER);
   assign vrow      = is_vert ? cur_ff : row_ff;
   assign vcol      = is_vert ? col_ff : cur_ff;
   assign start_sel = is_vert ? row_ff : col_ff;
   assign rd_row    = vrow[RW-1:0];
   assign rd_col    = vcol[CW-1:0];

   assign total_nx = (empty_ff && (total_ff != kld_pkg::CNT_MAX))
                     ? total_ff + kld_pkg::CNT_W'(1) : total_ff;
   assign hor_nx   = (empty_ff && !is_vert && (hor_ff != kld_pkg::CNT_MAX))
                     ? hor_ff + kld_pkg::CNT_W'(1) : hor_ff;
   assign ver_nx   = (empty_ff && is_vert && (ver_ff != kld_pkg::CNT_MAX))
                     ? ver_ff + kld_pkg::CNT_W'(1) : ver_ff;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kld_pkg::ST_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         attempt_ff   <= '0;
         total_ff     <= '0;
         hor_ff       <= '0;
         ver_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         attempt_ff   <= attempt_in;
         total_ff     <= total_in;
         hor_ff       <= hor_in;
         ver_ff       <= ver_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      cur_ff      <= cur_in;
      idx_ff      <= idx_in;
      empty_ff    <= empty_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      empty_in     = empty_ff;
      attempt_in   = attempt_ff;
      total_in     = total_ff;
      hor_in       = hor_ff;
      ver_in       = ver_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      req_ch.ready = 1'b0;
      unit_op      = cur_ff + ONE_W;
      unit_mod     = is_vert ? ROWS_W : COLS_W;
      wr_en        = 1'b0;
      wr_row       = vrow[RW-1:0];
      wr_col       = vcol[CW-1:0];
      wr_mark      = is_vert ? kld_pkg::MARK_VER : kld_pkg::MARK_HOR;

      unique case (state_ff)
         kld_pkg::ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_row   = row_ff[RW-1:0];
            wr_col   = col_ff[CW-1:0];
            wr_mark  = kld_pkg::MARK_EMPTY;
            unit_op  = col_ff + ONE_W;
            unit_mod = COLS_W;
            col_in   = unit_res;
            if (unit_wrap) begin
               row_in = row_ff + ONE_W;
               if (row_ff == ROWS_W - ONE_W) begin
                  state_in = kld_pkg::ST_IDLE;
               end
            end
         end
         kld_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               func_in  = req_ch.data.func;
               row_in   = WW'(req_ch.data.row);
               col_in   = WW'(req_ch.data.col);
               state_in = kld_pkg::ST_RED_ROW;
            end
         end
         kld_pkg::ST_RED_ROW: begin
            unit_op  = row_ff;
            unit_mod = ROWS_W;
            if (unit_wrap) begin
               row_in = unit_res;
            end else begin
               state_in = kld_pkg::ST_RED_COL;
            end
         end
         kld_pkg::ST_RED_COL: begin
            unit_op  = col_ff;
            unit_mod = COLS_W;
            if (unit_wrap) begin
               col_in = unit_res;
            end else begin
               cur_in   = start_sel;
               idx_in   = '0;
               empty_in = 1'b1;
               state_in = kld_pkg::ST_READ;
            end
         end
         kld_pkg::ST_READ: begin
            state_in = kld_pkg::ST_TEST;
         end
         kld_pkg::ST_TEST: begin
            empty_in = empty_ff && (rd_mark == kld_pkg::MARK_EMPTY);
            cur_in   = unit_res;
            if (idx_ff == KLAST) begin
               idx_in   = '0;
               cur_in   = start_sel;
               state_in = empty_in ? kld_pkg::ST_WRITE : kld_pkg::ST_FINISH;
            end else begin
               idx_in   = idx_ff + KW'(1);
               state_in = kld_pkg::ST_READ;
            end
         end
         kld_pkg::ST_WRITE: begin
            wr_en  = 1'b1;
            cur_in = unit_res;
            if (idx_ff == KLAST) begin
               state_in = kld_pkg::ST_FINISH;
            end else begin
               idx_in = idx_ff + KW'(1);
            end
         end
         kld_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.placed            = empty_ff;
               rsp_data_in.attempt_number    = attempt_ff;
               rsp_data_in.start_index       = start_sel[kld_pkg::COORD_W-1:0];
               rsp_data_in.total_placed      = total_nx;
               rsp_data_in.horizontal_placed = hor_nx;
               rsp_data_in.vertical_placed   = ver_nx;
               total_in                      = total_nx;
               hor_in                        = hor_nx;
               ver_in                        = ver_nx;
               if (attempt_ff != kld_pkg::ATT_MAX) begin
                  attempt_in = attempt_ff + kld_pkg::ATT_W'(1);
               end
               state_in = kld_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kld_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[tb/tb_kmer_lattice_deposition.sv]
// Testbench for kmer_lattice_deposition: directed and random jamming tests
// against an in-bench lattice predictor. Depends on kld_pkg, kld_if and the block RTL.
module tb_kmer_lattice_deposition;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS = 16;
   localparam int COLS = 16;
   localparam int KLEN = 3;
   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLS);
   localparam logic FUNC_HOR = 1'b0;
   localparam int MAX_IDLE = 11;
   localparam int RANDOM_REQUESTS = 650;
   localparam int DRAIN_CYCLES = 24;

   logic clock;
   logic reset;

   kld_req_if req_ch ();
   kld_rsp_if rsp_ch ();

   kmer_lattice_deposition #(
      .ROWS(ROWS),
      .COLS(COLS),
      .KLEN(KLEN)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   kld_pkg::mark_type lattice_marks [ROWS][COLS];
   logic [kld_pkg::CNT_W-1:0] placed_sum;
   logic [kld_pkg::CNT_W-1:0] placed_hor;
   logic [kld_pkg::CNT_W-1:0] placed_ver;
   logic [kld_pkg::ATT_W-1:0] attempt_cnt;
   kld_pkg::rsp_type          outcome_q [$];
   int                        fail_count;
   bit                        quiet;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("Test completed with failures");
      $finish;
   end

   task automatic flag_error(string msg);
      fail_count++;
      $display("ERROR @%0t: %s", $time, msg);
   endtask

   function automatic int idle_draw();
      return quiet ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   function automatic bit kmer_fits(logic func, int r0, int c0);
      int r;
      int c;
      kmer_fits = 1'b1;
      for (int i = 0; i < KLEN; i++) begin
         r = (func == kld_pkg::FUNC_VER) ? (r0 + i) % ROWS : r0;
         c = (func == kld_pkg::FUNC_VER) ? c0 : (c0 + i) % COLS;
         if (lattice_marks[RW'(r)][CW'(c)] != kld_pkg::MARK_EMPTY) kmer_fits = 1'b0;
      end
   endfunction

   task automatic predict_deposition(kld_pkg::req_type rq);
      kld_pkg::rsp_type outcome;
      int r0;
      int c0;
      int r;
      int c;
      logic vert;
      vert = (rq.func == kld_pkg::FUNC_VER);
      r0 = rq.row % ROWS;
      c0 = rq.col % COLS;
      outcome.placed = kmer_fits(rq.func, r0, c0);
      outcome.attempt_number = attempt_cnt;
      outcome.start_index = vert ? 4'(r0) : 4'(c0);
      if (outcome.placed) begin
         for (int i = 0; i < KLEN; i++) begin
            r = vert ? (r0 + i) % ROWS : r0;
            c = vert ? c0 : (c0 + i) % COLS;
            lattice_marks[RW'(r)][CW'(c)] = vert ? kld_pkg::MARK_VER : kld_pkg::MARK_HOR;
         end
         if (placed_sum != kld_pkg::CNT_MAX) placed_sum++;
         if (vert) begin
            if (placed_ver != kld_pkg::CNT_MAX) placed_ver++;
         end else begin
            if (placed_hor != kld_pkg::CNT_MAX) placed_hor++;
         end
      end
      if (attempt_cnt != kld_pkg::ATT_MAX) attempt_cnt++;
      outcome.total_placed = placed_sum;
      outcome.horizontal_placed = placed_hor;
      outcome.vertical_placed = placed_ver;
      outcome_q.push_back(outcome);
   endtask

   // valid stays high across back-to-back requests
   task automatic send_request(logic func, logic [3:0] row, logic [3:0] col);
      kld_pkg::req_type rq;
      int gap;
      rq.func = func;
      rq.row = row;
      rq.col = col;
      gap = idle_draw();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= rq;
      do @(posedge clock); while (!req_ch.ready);
      predict_deposition(rq);
   endtask

   task automatic test_directed_placements();
      send_request(FUNC_HOR, 4'd0, 4'd0);
      send_request(FUNC_HOR, 4'd0, 4'd0);
      send_request(FUNC_HOR, 4'd15, 4'd15);
      send_request(kld_pkg::FUNC_VER, 4'd15, 4'd15);
      send_request(kld_pkg::FUNC_VER, 4'd14, 4'd8);
      send_request(kld_pkg::FUNC_VER, 4'd0, 4'd0);
      send_request(FUNC_HOR, 4'd1, 4'd0);
      send_request(kld_pkg::FUNC_VER, 4'd15, 4'd1);
      send_request(kld_pkg::FUNC_VER, 4'd3, 4'd4);
      send_request(FUNC_HOR, 4'd4, 4'd2);
      send_request(FUNC_HOR, 4'd4, 4'd5);
      send_request(FUNC_HOR, 4'd5, 4'd3);
      send_request(kld_pkg::FUNC_VER, 4'd15, 4'd0);
      send_request(FUNC_HOR, 4'd10, 4'd5);
      send_request(kld_pkg::FUNC_VER, 4'd5, 4'd10);
      send_request(kld_pkg::FUNC_VER, 4'd15, 4'd8);
   endtask

   // mostly requests that still fit, so the lattice runs into jamming
   task automatic test_random_jamming();
      int start;
      int idx;
      bit found;
      logic f;
      logic [3:0] r;
      logic [3:0] c;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
         found = 1'b0;
         if ($urandom_range(0, 9) < 6) begin
            start = $urandom_range(0, 2 * ROWS * COLS - 1);
            for (int k = 0; k < 2 * ROWS * COLS && !found; k++) begin
               idx = (start + k) % (2 * ROWS * COLS);
               f = idx[8];
               r = idx[7:4];
               c = idx[3:0];
               found = kmer_fits(f, int'(r), int'(c));
            end
         end
         if (!found) begin
            f = 1'($urandom_range(0, 1));
            r = 4'($urandom_range(0, 15));
            c = 4'($urandom_range(0, 15));
         end
         send_request(f, r, c);
      end
      quiet = 1'b0;
   endtask

   initial begin
      int stall;
      kld_pkg::rsp_type got;
      kld_pkg::rsp_type exp_rsp;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = idle_draw();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            do @(posedge clock); while (!rsp_ch.valid);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got = rsp_ch.data;
         if (outcome_q.size() == 0) begin
            flag_error($sformatf("unexpected result, attempt %0d", got.attempt_number));
         end else begin
            exp_rsp = outcome_q.pop_front();
            if (got.placed !== exp_rsp.placed)
               flag_error($sformatf("attempt %0d placed: got %0d expected %0d",
                  exp_rsp.attempt_number, got.placed, exp_rsp.placed));
            if (got.attempt_number !== exp_rsp.attempt_number)
               flag_error($sformatf("attempt_number: got %0d expected %0d",
                  got.attempt_number, exp_rsp.attempt_number));
            if (got.start_index !== exp_rsp.start_index)
               flag_error($sformatf("attempt %0d start_index: got %0d expected %0d",
                  exp_rsp.attempt_number, got.start_index, exp_rsp.start_index));
            if (got.total_placed !== exp_rsp.total_placed)
               flag_error($sformatf("attempt %0d total_placed: got %0d expected %0d",
                  exp_rsp.attempt_number, got.total_placed, exp_rsp.total_placed));
            if (got.horizontal_placed !== exp_rsp.horizontal_placed)
               flag_error($sformatf("attempt %0d horizontal_placed: got %0d expected %0d",
                  exp_rsp.attempt_number, got.horizontal_placed,
                  exp_rsp.horizontal_placed));
            if (got.vertical_placed !== exp_rsp.vertical_placed)
               flag_error($sformatf("attempt %0d vertical_placed: got %0d expected %0d",
                  exp_rsp.attempt_number, got.vertical_placed, exp_rsp.vertical_placed));
         end
      end
   end

   initial begin
      foreach (lattice_marks[r, c]) lattice_marks[r][c] = kld_pkg::MARK_EMPTY;
      placed_sum = '0;
      placed_hor = '0;
      placed_ver = '0;
      attempt_cnt = '0;
      fail_count = 0;
      quiet = 1'b0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_placements();
      test_random_jamming();
      req_ch.valid <= 1'b0;

      while (outcome_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
